// ----- rtl/assert_macros.svh -----
// ============================================================================
// assertion macros
// shared concurrent assertion forms, clocked on clk with active-low reset
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lknp_pkg.sv -----
// ============================================================================
// lknp_pkg
// types and constants of the key letter settings parser
// ============================================================================
`default_nettype none

package lknp_pkg;

    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int OUT_W    = 16;
    localparam int STATUS_W = 3;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_D = 8'h44;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_H = 8'h48;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_I = 8'h49;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;
    localparam logic [CHAR_W-1:0] HEX_LETTER_BASE = 8'd10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // parse mode, field modes double as the error status codes
    typedef enum logic [STATUS_W-1:0] {
        MODE_IDLE  = 3'd0,
        MODE_PORT  = 3'd1,
        MODE_IRQ   = 3'd2,
        MODE_DMA8  = 3'd3,
        MODE_DMA16 = 3'd4,
        MODE_STOP  = 3'd5
    } mode_t;

    localparam logic [STATUS_W-1:0] STATUS_OK = 3'd0;

    typedef enum logic [2:0] {
        KEY_NONE,
        KEY_PORT,
        KEY_IRQ,
        KEY_DMA8,
        KEY_DMA16
    } key_t;

    // classified character
    typedef struct packed {
        key_t               key;
        logic               is_space;
        logic               hex_ok;
        logic               dec_ok;
        logic [DIGIT_W-1:0] digit;
        logic               is_final;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/lknp_in_if.sv -----
// ============================================================================
// lknp_in_if
// character channel: one settings character per item, final flag on the last
// ============================================================================
`default_nettype none

interface lknp_in_if
    import lknp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              is_final;

    modport source (output valid, output char_in, output is_final, input ready);
    modport sink (input valid, input char_in, input is_final, output ready);
endinterface

`default_nettype wire

// ----- rtl/lknp_out_if.sv -----
// ============================================================================
// lknp_out_if
// result channel: parsed values and status of one settings string
// ============================================================================
`default_nettype none

interface lknp_out_if
    import lknp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OUT_W-1:0]    port_value;
    logic [OUT_W-1:0]    irq_value;
    logic [OUT_W-1:0]    dma8_value;
    logic [OUT_W-1:0]    dma16_value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output port_value, output irq_value,
                    output dma8_value, output dma16_value, output status,
                    input ready);
    modport sink (input valid, input port_value, input irq_value,
                  input dma8_value, input dma16_value, input status,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/letter_keyed_number_parser.sv -----
// ============================================================================
// letter_keyed_number_parser
// key letter settings string parser: hex port, decimal irq, dma8 and dma16
// ============================================================================
//
//  channel | dir | items                          | ends when
//  --------+-----+--------------------------------+---------------------------
//  chars   | in  | one character, final flag      | every character
//  result  | out | four values and status         | once per final character
//
//  one character per cycle sustained while the result is not stalled; a
//  character reaches the field engine through a registered two-item queue
//  result appears the cycle after the final character leaves the queue
//  a stalled result holds the field engine; characters still queue up to two
//  reset clears parse state, queue and result valid at once
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module letter_keyed_number_parser
    import lknp_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    lknp_in_if.sink     chars,
    lknp_out_if.source  result
);

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t q_cmd;
    logic q_valid;
    logic q_ready;

    lknp_front u_front (
        .chars     (chars),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    lknp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (q_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    lknp_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .result    (result)
    );

    `ASSERT_IMPLY(a_full_not_empty, !chars.ready, q_valid, "queue full yet empty")
    `ASSERT_IMPLY(a_stall_holds_back, result.valid && !result.ready, !q_ready,
                  "field engine runs over a stalled result")
    `ASSERT_NEXT(a_final_gives_result, q_valid && q_ready && q_cmd.is_final,
                 result.valid, "final character gave no result")
    `ASSERT_IMPLY(a_status_range, result.valid, result.status <= MODE_DMA16,
                  "status out of range")

endmodule

`default_nettype wire

// ----- rtl/lknp_front.sv -----
// ============================================================================
// lknp_front
// classifies each character: key letter, space, hex and decimal digit value
// ============================================================================
`default_nettype none

module lknp_front
    import lknp_pkg::*;
(
    lknp_in_if.sink     chars,
    output cmd_t        cmd,
    output logic        cmd_valid,
    input  logic        cmd_ready
);

    logic [CHAR_W-1:0] upper;
    logic [CHAR_W-1:0] num_off;
    logic [CHAR_W-1:0] let_off;
    logic              is_num;
    logic              is_hex_letter;

    assign cmd_valid   = chars.valid;
    assign chars.ready = cmd_ready;

    always_comb
    begin
        if (chars.char_in >= CHAR_LOWER_A && chars.char_in <= CHAR_LOWER_Z)
        begin
            upper = chars.char_in - CASE_OFFSET;
        end
        else
        begin
            upper = chars.char_in;
        end

        is_num        = (upper >= CHAR_ZERO) && (upper <= CHAR_NINE);
        is_hex_letter = (upper >= CHAR_UPPER_A) && (upper <= CHAR_UPPER_F);
        num_off       = upper - CHAR_ZERO;
        let_off       = upper - CHAR_UPPER_A + HEX_LETTER_BASE;

        cmd.key = KEY_NONE;
        case (upper)
            CHAR_UPPER_A: cmd.key = KEY_PORT;
            CHAR_UPPER_I: cmd.key = KEY_IRQ;
            CHAR_UPPER_D: cmd.key = KEY_DMA8;
            CHAR_UPPER_H: cmd.key = KEY_DMA16;
            default:      cmd.key = KEY_NONE;
        endcase

        cmd.is_space = (chars.char_in == CHAR_SPACE);
        cmd.dec_ok   = is_num;
        cmd.hex_ok   = is_num || is_hex_letter;
        cmd.digit    = is_num ? num_off[DIGIT_W-1:0] : let_off[DIGIT_W-1:0];
        cmd.is_final = chars.is_final;
    end

endmodule

`default_nettype wire

// ----- rtl/lknp_queue.sv -----
// ============================================================================
// lknp_queue
// short command queue between the classifier and the field engine
// ============================================================================
`default_nettype none

module lknp_queue
    import lknp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t push_data,
    input  logic push_valid,
    output logic push_ready,
    output cmd_t pop_data,
    output logic pop_valid,
    input  logic pop_ready
);

    cmd_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lknp_back.sv -----
// ============================================================================
// lknp_back
// field engine: parse mode, value accumulators, error code and result register
// ============================================================================
`default_nettype none

module lknp_back
    import lknp_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    lknp_out_if.source  result
);

    localparam int SUM_W = VALUE_WIDTH + DIGIT_W;

    mode_t                  mode_reg;
    mode_t                  mode_next;
    logic [VALUE_WIDTH-1:0] port_reg;
    logic [VALUE_WIDTH-1:0] port_next;
    logic [VALUE_WIDTH-1:0] irq_reg;
    logic [VALUE_WIDTH-1:0] irq_next;
    logic [VALUE_WIDTH-1:0] dma8_reg;
    logic [VALUE_WIDTH-1:0] dma8_next;
    logic [VALUE_WIDTH-1:0] dma16_reg;
    logic [VALUE_WIDTH-1:0] dma16_next;
    logic [STATUS_W-1:0]    err_reg;
    logic [STATUS_W-1:0]    err_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic [OUT_W-1:0]       res_port_reg;
    logic [OUT_W-1:0]       res_irq_reg;
    logic [OUT_W-1:0]       res_dma8_reg;
    logic [OUT_W-1:0]       res_dma16_reg;
    logic [STATUS_W-1:0]    res_status_reg;
    logic [OUT_W-1:0]       ext_port;
    logic [OUT_W-1:0]       ext_irq;
    logic [OUT_W-1:0]       ext_dma8;
    logic [OUT_W-1:0]       ext_dma16;
    logic [VALUE_WIDTH-1:0] sel_acc;
    logic [VALUE_WIDTH-1:0] hex_acc;
    logic [SUM_W-1:0]       dec_sum;
    logic [VALUE_WIDTH-1:0] new_acc;
    logic                   digit_ok;
    logic                   take;

    assign cmd_ready = !res_valid_reg || result.ready;
    assign take      = cmd_valid && cmd_ready;

    // current field accumulator and its update
    always_comb
    begin
        case (mode_reg)
            MODE_PORT:  sel_acc = port_reg;
            MODE_IRQ:   sel_acc = irq_reg;
            MODE_DMA8:  sel_acc = dma8_reg;
            default:    sel_acc = dma16_reg;
        endcase
        hex_acc  = {sel_acc[VALUE_WIDTH-DIGIT_W-1:0], cmd.digit};
        dec_sum  = ({{DIGIT_W{1'b0}}, sel_acc} << 3) + ({{DIGIT_W{1'b0}}, sel_acc} << 1)
                   + {{VALUE_WIDTH{1'b0}}, cmd.digit};
        digit_ok = (mode_reg == MODE_PORT) ? cmd.hex_ok : cmd.dec_ok;
        new_acc  = (mode_reg == MODE_PORT) ? hex_acc : dec_sum[VALUE_WIDTH-1:0];
    end

    always_comb
    begin
        mode_next  = mode_reg;
        port_next  = port_reg;
        irq_next   = irq_reg;
        dma8_next  = dma8_reg;
        dma16_next = dma16_reg;
        err_next   = err_reg;
        if (take)
        begin
            case (mode_reg)
                MODE_STOP:
                begin
                    mode_next = MODE_STOP;
                end
                MODE_IDLE:
                begin
                    case (cmd.key)
                        KEY_PORT:
                        begin
                            mode_next = MODE_PORT;
                            port_next = '0;
                        end
                        KEY_IRQ:
                        begin
                            mode_next = MODE_IRQ;
                            irq_next  = '0;
                        end
                        KEY_DMA8:
                        begin
                            mode_next = MODE_DMA8;
                            dma8_next = '0;
                        end
                        KEY_DMA16:
                        begin
                            mode_next  = MODE_DMA16;
                            dma16_next = '0;
                        end
                        default:
                        begin
                            mode_next = MODE_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    if (cmd.is_space)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (!digit_ok)
                    begin
                        err_next  = mode_reg;
                        mode_next = MODE_STOP;
                    end
                    else
                    begin
                        case (mode_reg)
                            MODE_PORT:  port_next  = new_acc;
                            MODE_IRQ:   irq_next   = new_acc;
                            MODE_DMA8:  dma8_next  = new_acc;
                            default:    dma16_next = new_acc;
                        endcase
                    end
                end
            endcase
        end
    end

    // values as seen on the result channel
    generate
        if (VALUE_WIDTH >= OUT_W)
        begin : g_trunc
            assign ext_port  = port_next[OUT_W-1:0];
            assign ext_irq   = irq_next[OUT_W-1:0];
            assign ext_dma8  = dma8_next[OUT_W-1:0];
            assign ext_dma16 = dma16_next[OUT_W-1:0];
        end
        else
        begin : g_zext
            assign ext_port  = {{(OUT_W-VALUE_WIDTH){1'b0}}, port_next};
            assign ext_irq   = {{(OUT_W-VALUE_WIDTH){1'b0}}, irq_next};
            assign ext_dma8  = {{(OUT_W-VALUE_WIDTH){1'b0}}, dma8_next};
            assign ext_dma16 = {{(OUT_W-VALUE_WIDTH){1'b0}}, dma16_next};
        end
    endgenerate

    always_comb
    begin
        if (take && cmd.is_final)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            port_reg      <= '0;
            irq_reg       <= '0;
            dma8_reg      <= '0;
            dma16_reg     <= '0;
            err_reg       <= STATUS_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take && cmd.is_final)
            begin
                // string done, back to the reset state
                mode_reg  <= MODE_IDLE;
                port_reg  <= '0;
                irq_reg   <= '0;
                dma8_reg  <= '0;
                dma16_reg <= '0;
                err_reg   <= STATUS_OK;
            end
            else
            begin
                mode_reg  <= mode_next;
                port_reg  <= port_next;
                irq_reg   <= irq_next;
                dma8_reg  <= dma8_next;
                dma16_reg <= dma16_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && cmd.is_final)
        begin
            res_port_reg   <= ext_port;
            res_irq_reg    <= ext_irq;
            res_dma8_reg   <= ext_dma8;
            res_dma16_reg  <= ext_dma16;
            res_status_reg <= err_next;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.port_value  = res_port_reg;
    assign result.irq_value   = res_irq_reg;
    assign result.dma8_value  = res_dma8_reg;
    assign result.dma16_value = res_dma16_reg;
    assign result.status      = res_status_reg;

endmodule

`default_nettype wire
